// ===== sv/pbe_pkg.sv =====
// Shared types, codes and helpers for the paged bitmap engine.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package pbe_pkg;

    localparam int PAGE_BITS_LOG2_DEF = 12;
    localparam int PAGE_COUNT_DEF     = 64;

    localparam int ACT_W = 4;
    localparam int IDX_W = 18;
    localparam int END_W = 19;
    localparam int CNT_W = 19;
    localparam logic [CNT_W-1:0] CNT_RESET = 19'd262144;

    // action codes
    localparam logic [ACT_W-1:0] ACT_SET         = 4'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR       = 4'd1;
    localparam logic [ACT_W-1:0] ACT_TEST        = 4'd2;
    localparam logic [ACT_W-1:0] ACT_SET_RANGE   = 4'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR_RANGE = 4'd4;
    localparam logic [ACT_W-1:0] ACT_TEST_SET    = 4'd5;
    localparam logic [ACT_W-1:0] ACT_TEST_CLEAR  = 4'd6;
    localparam logic [ACT_W-1:0] ACT_FIND_CLEAR  = 4'd7;
    localparam logic [ACT_W-1:0] ACT_SET_ALL     = 4'd8;
    localparam logic [ACT_W-1:0] ACT_CLEAR_ALL   = 4'd9;

    // page summary codes
    localparam logic [1:0] SUM_CLEAR = 2'd0;
    localparam logic [1:0] SUM_SET   = 2'd1;
    localparam logic [1:0] SUM_MIXED = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [IDX_W-1:0] start_index;
        logic [END_W-1:0] end_index;
    } t_item;

    typedef struct packed {
        logic             status;
        logic             answer_flag;
        logic [IDX_W-1:0] found_index;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_ALL, ST_PG_RD, ST_PG_EVAL, ST_W_RD, ST_W_WR,
        ST_W_CHK, ST_SUM_WR, ST_NEXT, ST_FIN, ST_RESULT
    } t_state;

    typedef struct packed {
        logic load;
        logic all_op;
        logic page_init;
        logic page_next;
        logic sum_rd;
        logic sum_wr_want;
        logic sum_wr_norm;
        logic hit_cap;
        logic word_init;
        logic word_next;
        logic word_rd;
        logic word_wr;
        logic word_chk;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic empty;
        logic is_all;
        logic is_write;
        logic full_page;
        logic eq_want;
        logic mixed;
        logic hit;
        logic word_last;
        logic word_hit;
        logic page_last;
    } t_stat;

    // index of lowest set bit (0 when none)
    function automatic logic [5:0] lowest_set(input logic [63:0] x);
        logic [5:0] n;
        n = '0;
        for (int i = 63; i >= 0; i--) begin
            if (x[i]) n = 6'(i);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ===== sv/paged_bitmap_engine.sv =====
// Paged bitmap engine: one result beat per accepted item, receiver cannot stall.
// Bad and empty items go from decode to the result; set/clear-all pass the all-pages state.
// Other items walk each page in range: summary read, then evaluation, where a test or search
// may stop; reads walk a mixed page per word, and so do writes that change part of a page (every word).
// One item at a time: busy stays high through the result beat; items are taken only when idle.
// Sync active-low reset: all pages all-clear, bit_count 262144; word store unreset.
`default_nettype none
module paged_bitmap_engine #(
    parameter int PAGE_BITS_LOG2 = pbe_pkg::PAGE_BITS_LOG2_DEF,
    parameter int PAGE_COUNT     = pbe_pkg::PAGE_COUNT_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire pbe_pkg::t_item            i_item,
    output logic                           o_done,
    output pbe_pkg::t_result               o_result,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [pbe_pkg::CNT_W-1:0] i_cfg_data
);

    pbe_pkg::t_cmd  cmd;
    pbe_pkg::t_stat stat;

    // config beats are always taken; the user must send them only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    // sequencer: state machine for the page/word walk
    pbe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    // stores, range decode and result register
    pbe_dp #(
        .PAGE_BITS_LOG2 (PAGE_BITS_LOG2),
        .PAGE_COUNT     (PAGE_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid & o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_result    (o_result)
    );

    // result strobe lasts exactly one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than one cycle");

    // accepted item keeps the engine busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("item accepted but engine not busy");

    // invalid results carry no answer
    a_bad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status) |-> (!o_result.answer_flag && o_result.found_index == '0))
        else $error("invalid result with nonzero answer");

    // found index only with a hit
    a_found_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.answer_flag) |-> (o_result.found_index == '0))
        else $error("found index without flag");

endmodule
`default_nettype wire

// ===== sv/pbe_ctrl.sv =====
// Sequencer for the paged bitmap engine: walks pages and words.
// Depends on pbe_pkg (state enum, command and status structs).
`default_nettype none
module pbe_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire pbe_pkg::t_stat i_stat,
    output pbe_pkg::t_cmd      o_cmd,
    output logic               busy,
    output logic               o_done
);

    pbe_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= pbe_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pbe_pkg::ST_IDLE:    if (start) n_state = pbe_pkg::ST_DECODE;
            pbe_pkg::ST_DECODE: begin
                if (i_stat.bad)         n_state = pbe_pkg::ST_FIN;
                else if (i_stat.is_all) n_state = pbe_pkg::ST_ALL;
                else if (i_stat.empty)  n_state = pbe_pkg::ST_FIN;
                else                    n_state = pbe_pkg::ST_PG_RD;
            end
            pbe_pkg::ST_ALL:     n_state = pbe_pkg::ST_FIN;
            pbe_pkg::ST_PG_RD:   n_state = pbe_pkg::ST_PG_EVAL;
            pbe_pkg::ST_PG_EVAL: begin
                if (i_stat.is_write) begin
                    if (i_stat.full_page || i_stat.eq_want) n_state = pbe_pkg::ST_NEXT;
                    else                                    n_state = pbe_pkg::ST_W_RD;
                end else begin
                    if (i_stat.mixed)    n_state = pbe_pkg::ST_W_RD;
                    else if (i_stat.hit) n_state = pbe_pkg::ST_FIN;
                    else                 n_state = pbe_pkg::ST_NEXT;
                end
            end
            pbe_pkg::ST_W_RD:
                n_state = i_stat.is_write ? pbe_pkg::ST_W_WR : pbe_pkg::ST_W_CHK;
            pbe_pkg::ST_W_WR:
                n_state = i_stat.word_last ? pbe_pkg::ST_SUM_WR : pbe_pkg::ST_W_RD;
            pbe_pkg::ST_SUM_WR:  n_state = pbe_pkg::ST_NEXT;
            pbe_pkg::ST_W_CHK: begin
                if (i_stat.word_hit)       n_state = pbe_pkg::ST_FIN;
                else if (i_stat.word_last) n_state = pbe_pkg::ST_NEXT;
                else                       n_state = pbe_pkg::ST_W_RD;
            end
            pbe_pkg::ST_NEXT:
                n_state = i_stat.page_last ? pbe_pkg::ST_FIN : pbe_pkg::ST_PG_RD;
            pbe_pkg::ST_FIN:     n_state = pbe_pkg::ST_RESULT;
            pbe_pkg::ST_RESULT:  n_state = pbe_pkg::ST_IDLE;
            default:             n_state = pbe_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        busy   = (r_state != pbe_pkg::ST_IDLE);
        o_done = (r_state == pbe_pkg::ST_RESULT);
        case (r_state)
            pbe_pkg::ST_IDLE:    o_cmd.load = start;
            pbe_pkg::ST_DECODE:  o_cmd.page_init = 1'b1;
            pbe_pkg::ST_ALL:     o_cmd.all_op = 1'b1;
            pbe_pkg::ST_PG_RD:   o_cmd.sum_rd = 1'b1;
            pbe_pkg::ST_PG_EVAL: begin
                if (i_stat.is_write) begin
                    if (i_stat.full_page)     o_cmd.sum_wr_want = 1'b1;
                    else if (!i_stat.eq_want) o_cmd.word_init = 1'b1;
                end else begin
                    if (i_stat.mixed)    o_cmd.word_init = 1'b1;
                    else if (i_stat.hit) o_cmd.hit_cap = 1'b1;
                end
            end
            pbe_pkg::ST_W_RD:    o_cmd.word_rd = 1'b1;
            pbe_pkg::ST_W_WR: begin
                o_cmd.word_wr   = 1'b1;
                o_cmd.word_next = !i_stat.word_last;
            end
            pbe_pkg::ST_SUM_WR:  o_cmd.sum_wr_norm = 1'b1;
            pbe_pkg::ST_W_CHK: begin
                o_cmd.word_chk  = 1'b1;
                o_cmd.word_next = !i_stat.word_hit && !i_stat.word_last;
            end
            pbe_pkg::ST_NEXT:    o_cmd.page_next = !i_stat.page_last;
            pbe_pkg::ST_FIN:     o_cmd.finish = 1'b1;
            pbe_pkg::ST_RESULT:  o_cmd = '0;
            default:             o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/pbe_dp.sv =====
// Datapath of the paged bitmap engine: page summary store, word store,
// range decode, masks and result register. Depends on pbe_pkg.
`default_nettype none
module pbe_dp #(
    parameter int PAGE_BITS_LOG2 = pbe_pkg::PAGE_BITS_LOG2_DEF,
    parameter int PAGE_COUNT     = pbe_pkg::PAGE_COUNT_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire pbe_pkg::t_item              i_item,
    input  wire logic                        i_cfg_valid,
    input  wire logic [pbe_pkg::CNT_W-1:0]   i_cfg_data,
    input  wire pbe_pkg::t_cmd               i_cmd,
    output pbe_pkg::t_stat                   o_stat,
    output pbe_pkg::t_result                 o_result
);

    localparam int PBL   = PAGE_BITS_LOG2;
    localparam int WB    = PBL - 6;
    localparam int WW    = (WB > 0) ? WB : 1;
    localparam int PW    = 1 << WB;
    localparam int PA    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int AW    = PA + WB;
    localparam int DEPTH = PAGE_COUNT * PW;
    localparam logic [31:0] TOTAL32 = 32'(PAGE_COUNT) << PBL;

    // item and config
    logic [pbe_pkg::CNT_W-1:0] r_bit_count;
    logic [pbe_pkg::ACT_W-1:0] r_action;
    logic [pbe_pkg::IDX_W-1:0] r_start;
    logic [pbe_pkg::END_W-1:0] r_end;

    // walk state
    logic [PA-1:0]          r_page;
    logic [WW-1:0]          r_word;
    logic [PAGE_COUNT-1:0]  r_valid;
    logic [1:0]             r_default;
    logic [1:0]             r_sum_mem [PAGE_COUNT];
    logic [1:0]             r_sum_q;
    logic [63:0]            r_word_mem [DEPTH];
    logic [63:0]            r_word_q;
    logic                   r_any1, r_any0, r_hit;
    logic [PBL-1:0]         r_off;
    pbe_pkg::t_result       r_res;

    logic [pbe_pkg::END_W-1:0] size, start19, eff_end, endm1;
    logic                      single, in_range_act, unknown, is_all, is_write, v, bad, empty;
    logic [PA-1:0]             first_pg, last_pg;
    logic [PBL-1:0]            lo, hi_m1;
    logic [WW-1:0]             w_lo, w_hi;
    logic [1:0]                want, sum_eff, norm;
    logic [5:0]                a, bm1;
    logic [63:0]               mask, src, new_word, x;
    logic [AW-1:0]             addr;
    logic                      word_last;
    logic [31:0]               found_full;
    pbe_pkg::t_result          res_n;

    always_comb begin
        size = (32'(r_bit_count) < TOTAL32) ? r_bit_count : TOTAL32[pbe_pkg::CNT_W-1:0];
        start19 = {1'b0, r_start};
        single  = (r_action <= pbe_pkg::ACT_TEST);
        in_range_act = (r_action >= pbe_pkg::ACT_SET_RANGE) &&
                       (r_action <= pbe_pkg::ACT_FIND_CLEAR);
        is_all  = (r_action == pbe_pkg::ACT_SET_ALL) || (r_action == pbe_pkg::ACT_CLEAR_ALL);
        unknown = (r_action > pbe_pkg::ACT_CLEAR_ALL);
        bad     = unknown || ((single || in_range_act) && (start19 >= size)) ||
                  (in_range_act && (r_end > size));
        eff_end = single ? (start19 + 19'd1) : r_end;
        empty   = in_range_act && (eff_end <= start19);
        endm1   = eff_end - 19'd1;
        first_pg = PA'(r_start >> PBL);
        last_pg  = PA'(endm1 >> PBL);
        lo    = (r_page == first_pg) ? r_start[PBL-1:0] : '0;
        hi_m1 = (r_page == last_pg) ? endm1[PBL-1:0] : '1;
        w_lo  = WW'(lo >> 6);
        w_hi  = WW'(hi_m1 >> 6);
        is_write = (r_action == pbe_pkg::ACT_SET) || (r_action == pbe_pkg::ACT_CLEAR) ||
                   (r_action == pbe_pkg::ACT_SET_RANGE) ||
                   (r_action == pbe_pkg::ACT_CLEAR_RANGE);
        v = is_write ? ((r_action == pbe_pkg::ACT_SET) || (r_action == pbe_pkg::ACT_SET_RANGE))
                     : ((r_action == pbe_pkg::ACT_TEST) ||
                        (r_action == pbe_pkg::ACT_TEST_CLEAR));
        want    = v ? pbe_pkg::SUM_SET : pbe_pkg::SUM_CLEAR;
        sum_eff = r_valid[r_page] ? r_sum_q : r_default;
        word_last = is_write ? (r_word == WW'(PW - 1)) : (r_word == w_hi);
        a   = (r_word == w_lo) ? lo[5:0] : 6'd0;
        bm1 = (r_word == w_hi) ? hi_m1[5:0] : 6'd63;
        mask = ((r_word >= w_lo) && (r_word <= w_hi)) ?
               (({64{1'b1}} << a) & ({64{1'b1}} >> (6'd63 - bm1))) : '0;
        if (sum_eff == pbe_pkg::SUM_MIXED)    src = r_word_q;
        else if (sum_eff == pbe_pkg::SUM_SET) src = '1;
        else                                  src = '0;
        new_word = v ? (src | mask) : (src & ~mask);
        x = (v ? r_word_q : ~r_word_q) & mask;
        addr = (AW'(r_page) << WB) | AW'(r_word);
        if (!r_any1)      norm = pbe_pkg::SUM_CLEAR;
        else if (!r_any0) norm = pbe_pkg::SUM_SET;
        else              norm = pbe_pkg::SUM_MIXED;
    end

    // result of the finished item
    always_comb begin
        found_full = (32'(r_page) << PBL) + 32'(r_off);
        res_n = '0;
        res_n.status = bad;
        if (!bad) begin
            case (r_action)
                pbe_pkg::ACT_TEST:       res_n.answer_flag = r_hit;
                pbe_pkg::ACT_TEST_SET,
                pbe_pkg::ACT_TEST_CLEAR: res_n.answer_flag = !empty && !r_hit;
                pbe_pkg::ACT_FIND_CLEAR: begin
                    res_n.answer_flag = r_hit;
                    res_n.found_index = r_hit ? found_full[pbe_pkg::IDX_W-1:0] : '0;
                end
                default:                 res_n.answer_flag = 1'b0;
            endcase
        end
    end

    always_comb begin
        o_stat.bad       = bad;
        o_stat.empty     = empty;
        o_stat.is_all    = is_all;
        o_stat.is_write  = is_write;
        o_stat.full_page = (lo == '0) && (hi_m1 == '1);
        o_stat.eq_want   = (sum_eff == want);
        o_stat.mixed     = (sum_eff == pbe_pkg::SUM_MIXED);
        o_stat.hit       = v ? (sum_eff == pbe_pkg::SUM_SET) : (sum_eff == pbe_pkg::SUM_CLEAR);
        o_stat.word_last = word_last;
        o_stat.word_hit  = (x != '0);
        o_stat.page_last = (r_page == last_pg);
    end

    assign o_result = r_res;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count <= pbe_pkg::CNT_RESET;
            r_valid     <= '0;
            r_default   <= pbe_pkg::SUM_CLEAR;
            r_hit       <= 1'b0;
        end else begin
            if (i_cfg_valid) r_bit_count <= i_cfg_data;
            if (i_cmd.load) r_hit <= 1'b0;
            if (i_cmd.hit_cap || (i_cmd.word_chk && (x != '0))) r_hit <= 1'b1;
            if (i_cmd.all_op) begin
                r_valid   <= '0;
                r_default <= (r_action == pbe_pkg::ACT_SET_ALL) ?
                             pbe_pkg::SUM_SET : pbe_pkg::SUM_CLEAR;
            end
            if (i_cmd.sum_wr_want || i_cmd.sum_wr_norm) r_valid[r_page] <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_item.action;
            r_start  <= i_item.start_index;
            r_end    <= i_item.end_index;
        end
        if (i_cmd.page_init) r_page <= first_pg;
        if (i_cmd.page_next) r_page <= r_page + PA'(1);
        if (i_cmd.word_init) begin
            r_word <= is_write ? '0 : w_lo;
            r_any1 <= 1'b0;
            r_any0 <= 1'b0;
        end
        if (i_cmd.word_next) r_word <= r_word + WW'(1);
        if (i_cmd.word_wr) begin
            if (new_word != '0) r_any1 <= 1'b1;
            if (new_word != '1) r_any0 <= 1'b1;
        end
        if (i_cmd.hit_cap) r_off <= lo;
        if (i_cmd.word_chk && (x != '0))
            r_off <= (PBL'(r_word) << 6) | PBL'(pbe_pkg::lowest_set(x));
        if (i_cmd.finish) r_res <= res_n;
    end

    // summary store
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_wr_want || i_cmd.sum_wr_norm)
            r_sum_mem[r_page] <= i_cmd.sum_wr_want ? want : norm;
        if (i_cmd.sum_rd) r_sum_q <= r_sum_mem[r_page];
    end

    // word store
    always_ff @(posedge i_clk) begin
        if (i_cmd.word_wr) r_word_mem[addr] <= new_word;
        if (i_cmd.word_rd) r_word_q <= r_word_mem[addr];
    end

endmodule
`default_nettype wire

// ===== test/paged_bitmap_engine_tb.sv =====
// Self-checking testbench for paged_bitmap_engine: directed and random actions,
// size register phases, a bit-accurate bitmap predictor and an in-order result check.
// Depends on pbe_pkg and the paged_bitmap_engine RTL only.
`default_nettype none
module paged_bitmap_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PG_LOG2   = 12;
    localparam int PG_BITS   = 1 << PG_LOG2;
    localparam int PG_CNT    = 64;
    localparam int PG_WORDS  = PG_BITS / 64;
    localparam int MAP_BITS  = PG_CNT * PG_BITS;
    localparam int END_SLACK = 50;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    pbe_pkg::t_item            i_item;
    logic                      o_done;
    pbe_pkg::t_result          o_result;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [pbe_pkg::CNT_W-1:0] i_cfg_data;

    paged_bitmap_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Bitmap predictor: page summaries plus word store, same collapse
    // rules as the engine (mixed page folds back once uniform).
    // ---------------------------------------------------------------
    logic [1:0]                page_state [PG_CNT];
    logic [63:0]               page_words [PG_CNT*PG_WORDS];
    logic [pbe_pkg::CNT_W-1:0] bitmap_size_reg;

    pbe_pkg::t_result pending_results[$];
    int      mismatch_count;
    int      items_sent;
    int      results_seen;
    int      size_writes;
    bit      gaps_on;

    function automatic logic [63:0] span_bits(int a, int b);
        logic [63:0] hi;
        hi = (b >= 64) ? '1 : ((64'd1 << b) - 64'd1);
        return hi & ~((64'd1 << a) - 64'd1);
    endfunction

    function automatic void fold_page(int p);
        bit any1, any0;
        any1 = 0;
        any0 = 0;
        for (int w = 0; w < PG_WORDS; w++) begin
            if (page_words[p*PG_WORDS+w] != '0) any1 = 1;
            if (page_words[p*PG_WORDS+w] != '1) any0 = 1;
        end
        if (!any1)      page_state[p] = pbe_pkg::SUM_CLEAR;
        else if (!any0) page_state[p] = pbe_pkg::SUM_SET;
        else            page_state[p] = pbe_pkg::SUM_MIXED;
    endfunction

    // write value v into bits [lo,hi) of page p
    function automatic void write_page_span(int p, int lo, int hi, bit v);
        logic [1:0]  want;
        logic [63:0] m;
        int          a, b, base;
        want = v ? pbe_pkg::SUM_SET : pbe_pkg::SUM_CLEAR;
        if (lo == 0 && hi == PG_BITS) begin
            page_state[p] = want;
            return;
        end
        if (page_state[p] == want) return;
        if (page_state[p] != pbe_pkg::SUM_MIXED) begin
            for (int w = 0; w < PG_WORDS; w++)
                page_words[p*PG_WORDS+w] = (page_state[p] == pbe_pkg::SUM_SET) ? '1 : '0;
            page_state[p] = pbe_pkg::SUM_MIXED;
        end
        for (int w = lo >> 6; w <= (hi - 1) >> 6; w++) begin
            base = w << 6;
            a = (lo > base) ? lo - base : 0;
            b = (hi - base < 64) ? hi - base : 64;
            m = span_bits(a, b);
            if (v) page_words[p*PG_WORDS+w] |= m;
            else   page_words[p*PG_WORDS+w] &= ~m;
        end
        fold_page(p);
    endfunction

    // first offset in [lo,hi) of page p equal to v, PG_BITS when none
    function automatic int find_in_page(int p, int lo, int hi, bit v);
        logic [63:0] x;
        int          a, b, base;
        if (page_state[p] == pbe_pkg::SUM_CLEAR) return v ? PG_BITS : lo;
        if (page_state[p] == pbe_pkg::SUM_SET)   return v ? lo : PG_BITS;
        for (int w = lo >> 6; w <= (hi - 1) >> 6; w++) begin
            base = w << 6;
            a = (lo > base) ? lo - base : 0;
            b = (hi - base < 64) ? hi - base : 64;
            x = (v ? page_words[p*PG_WORDS+w] : ~page_words[p*PG_WORDS+w]) & span_bits(a, b);
            if (x != '0) begin
                for (int i = 0; i < 64; i++)
                    if (x[i]) return base + i;
            end
        end
        return PG_BITS;
    endfunction

    function automatic pbe_pkg::t_result bitmap_predict(pbe_pkg::t_item it);
        pbe_pkg::t_result r;
        int      sz, s, e, base, lo, hi, f;
        bit      all_ok;
        r  = '0;
        sz = (int'(bitmap_size_reg) < MAP_BITS) ? int'(bitmap_size_reg) : MAP_BITS;
        s  = int'(it.start_index);
        e  = int'(it.end_index);
        case (it.action)
            pbe_pkg::ACT_SET, pbe_pkg::ACT_CLEAR, pbe_pkg::ACT_TEST: begin
                if (s >= sz) r.status = 1'b1;
                else if (it.action == pbe_pkg::ACT_TEST)
                    r.answer_flag = find_in_page(s >> PG_LOG2, s % PG_BITS,
                                                 s % PG_BITS + 1, 1'b1) != PG_BITS;
                else
                    write_page_span(s >> PG_LOG2, s % PG_BITS, s % PG_BITS + 1,
                                    it.action == pbe_pkg::ACT_SET);
            end
            pbe_pkg::ACT_SET_RANGE, pbe_pkg::ACT_CLEAR_RANGE, pbe_pkg::ACT_TEST_SET,
            pbe_pkg::ACT_TEST_CLEAR, pbe_pkg::ACT_FIND_CLEAR: begin
                if (s >= sz || e > sz) r.status = 1'b1;
                else if (e > s) begin
                    all_ok = 1;
                    for (int p = s >> PG_LOG2; p <= (e - 1) >> PG_LOG2; p++) begin
                        base = p << PG_LOG2;
                        lo = (s > base) ? s - base : 0;
                        hi = (e - base < PG_BITS) ? e - base : PG_BITS;
                        if (it.action == pbe_pkg::ACT_SET_RANGE ||
                            it.action == pbe_pkg::ACT_CLEAR_RANGE)
                            write_page_span(p, lo, hi, it.action == pbe_pkg::ACT_SET_RANGE);
                        else if (it.action == pbe_pkg::ACT_FIND_CLEAR) begin
                            f = find_in_page(p, lo, hi, 1'b0);
                            if (f != PG_BITS) begin
                                r.answer_flag = 1'b1;
                                r.found_index = pbe_pkg::IDX_W'(base + f);
                                break;
                            end
                        end else if (find_in_page(p, lo, hi,
                                     it.action == pbe_pkg::ACT_TEST_CLEAR) != PG_BITS) begin
                            all_ok = 0;
                            break;
                        end
                    end
                    if (it.action == pbe_pkg::ACT_TEST_SET ||
                        it.action == pbe_pkg::ACT_TEST_CLEAR)
                        r.answer_flag = all_ok;
                end
            end
            pbe_pkg::ACT_SET_ALL, pbe_pkg::ACT_CLEAR_ALL: begin
                for (int p = 0; p < PG_CNT; p++)
                    page_state[p] = (it.action == pbe_pkg::ACT_SET_ALL) ?
                                    pbe_pkg::SUM_SET : pbe_pkg::SUM_CLEAR;
            end
            default: r.status = 1'b1;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Reporting and result check. The receiver cannot stall, so every
    // o_done cycle is one result beat.
    // ---------------------------------------------------------------
    task automatic report(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        pbe_pkg::t_result want;
        if (i_rst_n && o_done) begin
            results_seen++;
            if (pending_results.size() == 0)
                report($sformatf("result beat with nothing expected: %p", o_result));
            else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status)
                    report($sformatf("status got %b want %b", o_result.status, want.status));
                if (o_result.answer_flag !== want.answer_flag)
                    report($sformatf("answer_flag got %b want %b",
                                     o_result.answer_flag, want.answer_flag));
                if (o_result.found_index !== want.found_index)
                    report($sformatf("found_index got %0d want %0d",
                                     o_result.found_index, want.found_index));
            end
        end
    end

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------
    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge i_clk);
    endtask

    // one item beat: start stays high across back-to-back beats
    task automatic send_item(pbe_pkg::t_item it);
        if (gaps_on && $urandom_range(0, 3) == 0) idle_burst();
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(bitmap_predict(it));
        items_sent++;
    endtask

    task automatic send(logic [pbe_pkg::ACT_W-1:0] act, int s, int e);
        pbe_pkg::t_item it;
        it.action      = act;
        it.start_index = pbe_pkg::IDX_W'(s);
        it.end_index   = pbe_pkg::END_W'(e);
        send_item(it);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // size register is only touched when the engine is idle
    task automatic write_size(int value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= pbe_pkg::CNT_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid     <= 1'b0;
        bitmap_size_reg = pbe_pkg::CNT_W'(value);
        size_writes++;
    endtask

    function automatic pbe_pkg::t_item random_item();
        pbe_pkg::t_item it;
        int    r, s, e, pg;
        r = $urandom_range(0, 99);
        if (r < 3)      it.action = pbe_pkg::ACT_W'($urandom_range(10, 15));
        else if (r < 4) it.action = ($urandom_range(0, 1) != 0) ?
                                    pbe_pkg::ACT_SET_ALL : pbe_pkg::ACT_CLEAR_ALL;
        else            it.action = pbe_pkg::ACT_W'($urandom_range(pbe_pkg::ACT_SET,
                                                                   pbe_pkg::ACT_FIND_CLEAR));
        // a large share of traffic lands on hot pages 0, 1 and 63 so that they go mixed and fold back
        r = $urandom_range(0, 9);
        if (r < 7) begin
            case ($urandom_range(0, 4))
                0: pg = 0;
                1: pg = 1;
                2: pg = 63;
                default: pg = $urandom_range(0, 63);
            endcase
            s = pg * PG_BITS + $urandom_range(0, PG_BITS - 1);
        end else
            s = $urandom_range(0, MAP_BITS - 1);
        r = $urandom_range(0, 99);
        if (r < 55)      e = s + $urandom_range(0, 200);
        else if (r < 75) e = s + $urandom_range(0, 9000);
        else if (r < 85) begin
            s = s & ~(PG_BITS - 1);
            e = s + PG_BITS * $urandom_range(1, 3);
        end else if (r < 90) e = s - $urandom_range(0, 3);
        else if (r < 96) e = $urandom_range(0, (1 << pbe_pkg::END_W) - 1);
        else             e = MAP_BITS;
        it.start_index = pbe_pkg::IDX_W'(s);
        it.end_index   = pbe_pkg::END_W'(e);
        return it;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        send(pbe_pkg::ACT_SET, 0, 0);
        send(pbe_pkg::ACT_SET, MAP_BITS - 1, 0);
        send(pbe_pkg::ACT_TEST, 0, 0);
        send(pbe_pkg::ACT_TEST, 1, 0);
        send(pbe_pkg::ACT_CLEAR, 0, 0);
        send(pbe_pkg::ACT_SET_RANGE, 100, 5000);            // spans two pages
        send(pbe_pkg::ACT_TEST_SET, 100, 5000);
        send(pbe_pkg::ACT_TEST_CLEAR, 0, 100);
        send(pbe_pkg::ACT_FIND_CLEAR, 200, 6000);           // offset honored, first clear at 5000
        send(pbe_pkg::ACT_SET_RANGE, 0, 100);
        send(pbe_pkg::ACT_FIND_CLEAR, 0, 5000);             // set page 0 skipped; no clear bit in page 1
        send(pbe_pkg::ACT_CLEAR_RANGE, 0, PG_BITS);         // whole set page becomes clear
        send(pbe_pkg::ACT_SET_RANGE, PG_BITS, 2 * PG_BITS);
        send(pbe_pkg::ACT_TEST_SET, 7, 7);                  // empty range tests false
        send(pbe_pkg::ACT_FIND_CLEAR, 9, 3);
        send(pbe_pkg::ACT_SET_RANGE, 10, MAP_BITS + 1);     // end past size
        send(pbe_pkg::ACT_SET_ALL, 0, 0);
        send(pbe_pkg::ACT_FIND_CLEAR, 0, MAP_BITS);
        send(pbe_pkg::ACT_CLEAR, 131072, 0);
        send(pbe_pkg::ACT_FIND_CLEAR, 0, MAP_BITS);
        send(pbe_pkg::ACT_CLEAR_ALL, 0, 0);
        send(pbe_pkg::ACT_TEST_CLEAR, 0, MAP_BITS);
        send(pbe_pkg::ACT_W'(10), 0, 0);
        send(pbe_pkg::ACT_W'(15), MAP_BITS - 1, (1 << pbe_pkg::END_W) - 1);
    endtask

    // edge sizes: one bit, zero bits, above the store's capacity
    task automatic test_size_edges();
        write_size(1);
        send(pbe_pkg::ACT_SET, 0, 0);
        send(pbe_pkg::ACT_SET, 1, 0);
        send(pbe_pkg::ACT_TEST_SET, 0, 1);
        send(pbe_pkg::ACT_FIND_CLEAR, 0, 2);
        write_size(0);
        send(pbe_pkg::ACT_TEST, 0, 0);
        send(pbe_pkg::ACT_SET_RANGE, 0, 0);
        send(pbe_pkg::ACT_CLEAR_ALL, 0, 0);
        write_size((1 << pbe_pkg::CNT_W) - 1);
        send(pbe_pkg::ACT_SET, MAP_BITS - 1, 0);
        send(pbe_pkg::ACT_TEST_SET, MAP_BITS - 10, MAP_BITS);
        send(pbe_pkg::ACT_CLEAR_RANGE, 0, MAP_BITS + 1);
    endtask

    task automatic test_random(int n, bit with_gaps);
        gaps_on = with_gaps;
        for (int i = 0; i < n; i++) begin
            send_item(random_item());
            // let everything drain once in a while before sending more
            if (with_gaps && $urandom_range(0, 99) == 0) wait_drained();
        end
        gaps_on = 0;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_item          = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        mismatch_count  = 0;
        items_sent      = 0;
        results_seen    = 0;
        size_writes     = 0;
        gaps_on         = 0;
        bitmap_size_reg = pbe_pkg::CNT_RESET;
        for (int p = 0; p < PG_CNT; p++) page_state[p] = pbe_pkg::SUM_CLEAR;
        for (int w = 0; w < PG_CNT * PG_WORDS; w++) page_words[w] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_size_edges();
        write_size(5000);
        test_random(200, 1);
        wait_drained();                 // sender holds off until all results are in
        write_size(int'(pbe_pkg::CNT_RESET));
        test_random(300, 1);
        write_size($urandom_range(1, MAP_BITS));
        test_random(250, 1);
        write_size(int'(pbe_pkg::CNT_RESET));
        test_random(150, 0);            // closing stretch, back to back

        wait_drained();
        repeat (END_SLACK) @(posedge i_clk);
        $display("Sent %0d items, checked %0d results, %0d size register writes.",
                 items_sent, results_seen, size_writes);
        $display("Covered all ten actions, bad codes, bad and empty ranges, page folding.");
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // hang guard
    initial begin
        #200_000_000;
        $display("Timeout with %0d results outstanding.", pending_results.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
`default_nettype wire
